[hdl/vrc4_pkg.sv]
// ----------------------------------------------------------------------------
// VRC2/VRC4 mapper package
// Shared types, codes and constants for the mapper banking and IRQ block.
// ----------------------------------------------------------------------------
package vrc4_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_CPU_XLATE = 2'd2,
        CMD_PPU_XLATE = 2'd3
    } cmd_t;

    localparam logic [2:0] TGT_UNMAPPED  = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM   = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM   = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM   = 3'd3;
    localparam logic [2:0] TGT_NAMETABLE = 3'd4;

    localparam logic [3:0] VAR_VRC2A  = 4'd0;
    localparam logic [3:0] VAR_VRC2B  = 4'd1;
    localparam logic [3:0] VAR_VRC2C  = 4'd2;
    localparam logic [3:0] VAR_VRC4A  = 4'd3;
    localparam logic [3:0] VAR_VRC4B  = 4'd4;
    localparam logic [3:0] VAR_VRC4C  = 4'd5;
    localparam logic [3:0] VAR_VRC4D  = 4'd6;
    localparam logic [3:0] VAR_VRC4E  = 4'd7;
    localparam logic [3:0] VAR_VRC4F  = 4'd8;
    localparam logic [3:0] VAR_MAP23  = 4'd10;
    localparam logic [3:0] VAR_MAP25  = 4'd11;

    localparam logic [1:0] CFG_VARIANT       = 2'd0;
    localparam logic [1:0] CFG_LAST_PRG_BANK = 2'd1;
    localparam logic [1:0] CFG_RAM_PRESENT   = 2'd2;

    localparam logic [3:0] GRP_PRG_SWITCH = 4'h8;
    localparam logic [3:0] GRP_MIRROR     = 4'h9;
    localparam logic [3:0] GRP_PRG_MIDDLE = 4'hA;
    localparam logic [3:0] GRP_CHR_FIRST  = 4'hB;
    localparam logic [3:0] GRP_CHR_1      = 4'hC;
    localparam logic [3:0] GRP_CHR_2      = 4'hD;
    localparam logic [3:0] GRP_CHR_LAST   = 4'hE;
    localparam logic [3:0] GRP_IRQ        = 4'hF;

    localparam logic [1:0] IRQ_LATCH_LO  = 2'd0;
    localparam logic [1:0] IRQ_LATCH_HI  = 2'd1;
    localparam logic [1:0] IRQ_CONTROL   = 2'd2;
    localparam logic [1:0] IRQ_ACK       = 2'd3;

    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;
    localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

    localparam logic signed [9:0] PRESCALE_RELOAD = 10'sd341;
    localparam logic signed [9:0] PRESCALE_STEP   = 10'sd3;
    localparam logic signed [9:0] PRESCALE_MIN    = -10'sd2;
    localparam logic [7:0]        IRQ_COUNT_TOP   = 8'hFF;

    typedef struct packed {
        logic [3:0] grp;
        logic [1:0] sub;
    } wr_reg_t;

    typedef struct packed {
        logic       irq_line;
        logic [2:0] target;
        logic [8:0] bank;
        logic       nametable_page;
    } result_t;

endpackage

[hdl/vrc4_mapper_banking_irq.sv]
// ----------------------------------------------------------------------------
// VRC2/VRC4 mapper banking and IRQ
// Bank registers, IRQ counter and address translation for the VRC2/VRC4
// cartridge mapper family.
//
// Each input item is one command: a CPU write, a CPU cycle tick, a CPU
// address translate or a PPU address translate. Every item gives exactly one
// result item carrying the IRQ level after the command and, for translates,
// the target memory, bank and nametable page.
// An item is processed in the cycle it is accepted; its result is registered,
// in the skid register while a result waits. The block takes one item per
// clock while the skid entry is empty. All state updates and the translation
// are done by one level of logic feeding register bank and result register.
// A two-entry output buffer (result register plus skid register) lets the
// block take one more item while a result waits; if the receiver keeps
// stalling, ready drops until the skid entry drains.
// Configuration writes (variant, last PRG bank, RAM present) are always
// accepted and should only be issued while the block is idle.
// Reset clears all mapper registers, loads the prescaler with 341 and
// restores the default configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vrc4_mapper_banking_irq
    import vrc4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [15:0] address,
    input  logic [7:0]  data,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        irq_line,
    output logic [2:0]  target,
    output logic [8:0]  bank,
    output logic        nametable_page,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [3:0]        variant_reg;
    logic [7:0]        last_prg_bank_reg;
    logic              ram_present_reg;

    logic [4:0]        prg_switch_bank_reg, prg_switch_bank_next;
    logic [4:0]        prg_middle_bank_reg, prg_middle_bank_next;
    logic              prg_swap_mode_reg, prg_swap_mode_next;
    logic [8:0]        chr_bank_reg [8];
    logic [8:0]        chr_bank_next [8];
    logic [1:0]        mirror_mode_reg, mirror_mode_next;
    logic [7:0]        irq_latch_reg, irq_latch_next;
    logic [7:0]        irq_count_reg, irq_count_next;
    logic              irq_enabled_reg, irq_enabled_next;
    logic              irq_enable_after_ack_reg, irq_enable_after_ack_next;
    logic              irq_cycle_mode_reg, irq_cycle_mode_next;
    logic signed [9:0] prescaler_reg, prescaler_next;
    logic              irq_pending_reg, irq_pending_next;

    result_t           res_reg, res_next;
    result_t           skid_reg, skid_next;
    result_t           new_res;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    cmd_t              cmd;
    logic              accept;
    logic              is_vrc2;
    wr_reg_t           wr_sel;
    logic [2:0]        chr_wr_idx;
    logic [3:0]        chr_grp_off;
    logic [7:0]        second_last;
    logic [13:0]       ppu_addr;
    logic [8:0]        chr_sel;
    logic              ps_expired;
    logic              fire;

    assign cmd       = cmd_t'(command);
    assign accept    = in_valid && in_ready;
    assign in_ready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign is_vrc2   = (variant_reg <= VAR_VRC2C);

    vrc4_pin_decode u_pin_decode (
        .variant (variant_reg),
        .address (address),
        .reg_sel (wr_sel)
    );

    assign chr_grp_off = wr_sel.grp - GRP_CHR_FIRST;
    assign chr_wr_idx  = {chr_grp_off[1:0], wr_sel.sub[1]};
    assign ps_expired  = (prescaler_reg <= 10'sd0);
    assign fire        = irq_cycle_mode_reg || ps_expired;

    // Register updates caused by writes and ticks.
    always_comb
    begin
        prg_switch_bank_next      = prg_switch_bank_reg;
        prg_middle_bank_next      = prg_middle_bank_reg;
        prg_swap_mode_next        = prg_swap_mode_reg;
        chr_bank_next             = chr_bank_reg;
        mirror_mode_next          = mirror_mode_reg;
        irq_latch_next            = irq_latch_reg;
        irq_count_next            = irq_count_reg;
        irq_enabled_next          = irq_enabled_reg;
        irq_enable_after_ack_next = irq_enable_after_ack_reg;
        irq_cycle_mode_next       = irq_cycle_mode_reg;
        prescaler_next            = prescaler_reg;
        irq_pending_next          = irq_pending_reg;

        if (accept && cmd == CMD_WRITE && address[15])
        begin
            unique case (wr_sel.grp)
                GRP_PRG_SWITCH:
                    prg_switch_bank_next = data[4:0];
                GRP_MIRROR:
                begin
                    if (is_vrc2)
                    begin
                        mirror_mode_next = {1'b0, data[0]};
                    end
                    else if (!wr_sel.sub[1])
                    begin
                        mirror_mode_next = data[1:0];
                    end
                    else
                    begin
                        prg_swap_mode_next = data[1];
                    end
                end
                GRP_PRG_MIDDLE:
                    prg_middle_bank_next = data[4:0];
                GRP_CHR_FIRST, GRP_CHR_1, GRP_CHR_2, GRP_CHR_LAST:
                begin
                    if (!wr_sel.sub[0])
                    begin
                        chr_bank_next[chr_wr_idx] =
                            {chr_bank_reg[chr_wr_idx][8:4], data[3:0]};
                    end
                    else
                    begin
                        chr_bank_next[chr_wr_idx] =
                            {data[4:0], chr_bank_reg[chr_wr_idx][3:0]};
                    end
                end
                GRP_IRQ:
                begin
                    unique case (wr_sel.sub)
                        IRQ_LATCH_LO:
                            irq_latch_next = {irq_latch_reg[7:4], data[3:0]};
                        IRQ_LATCH_HI:
                            irq_latch_next = {data[3:0], irq_latch_reg[3:0]};
                        IRQ_CONTROL:
                        begin
                            irq_enable_after_ack_next = data[0];
                            irq_enabled_next          = data[1];
                            irq_cycle_mode_next       = data[2];
                            if (data[1])
                            begin
                                irq_count_next = irq_latch_reg;
                                prescaler_next = PRESCALE_RELOAD;
                            end
                            irq_pending_next = 1'b0;
                        end
                        IRQ_ACK:
                        begin
                            irq_pending_next = 1'b0;
                            irq_enabled_next = irq_enable_after_ack_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && cmd == CMD_TICK && !is_vrc2)
        begin
            if (ps_expired)
            begin
                prescaler_next = prescaler_reg + PRESCALE_RELOAD - PRESCALE_STEP;
            end
            else
            begin
                prescaler_next = prescaler_reg - PRESCALE_STEP;
            end
            if (irq_enabled_reg && fire)
            begin
                if (irq_count_reg == IRQ_COUNT_TOP)
                begin
                    irq_pending_next = 1'b1;
                    irq_count_next   = irq_latch_reg;
                end
                else
                begin
                    irq_count_next = irq_count_reg + 8'd1;
                end
            end
        end
    end

    assign second_last = last_prg_bank_reg - 8'd1;
    assign ppu_addr    = address[13:0];
    assign chr_sel     = chr_bank_reg[ppu_addr[12:10]];

    // Translation of the current item against the state before it.
    always_comb
    begin
        new_res                = '0;
        new_res.irq_line       = irq_pending_next;
        unique case (cmd)
            CMD_CPU_XLATE:
            begin
                if (address[15:13] == 3'b011)
                begin
                    if (ram_present_reg)
                    begin
                        new_res.target = TGT_PRG_RAM;
                    end
                end
                else if (address[15])
                begin
                    new_res.target = TGT_PRG_ROM;
                    unique case (address[14:13])
                        2'd0:
                            new_res.bank = prg_swap_mode_reg ? {1'b0, second_last}
                                                             : {4'd0, prg_switch_bank_reg};
                        2'd1:
                            new_res.bank = {4'd0, prg_middle_bank_reg};
                        2'd2:
                            new_res.bank = prg_swap_mode_reg ? {4'd0, prg_switch_bank_reg}
                                                             : {1'b0, second_last};
                        default:
                            new_res.bank = {1'b0, last_prg_bank_reg};
                    endcase
                end
            end
            CMD_PPU_XLATE:
            begin
                if (!ppu_addr[13])
                begin
                    new_res.target = TGT_CHR_ROM;
                    new_res.bank   = (variant_reg == VAR_VRC2A) ? {1'b0, chr_sel[8:1]}
                                                                : chr_sel;
                end
                else if (ppu_addr[13:8] != 6'h3F)
                begin
                    new_res.target = TGT_NAMETABLE;
                    unique case (mirror_mode_reg)
                        MIR_VERTICAL:   new_res.nametable_page = ppu_addr[10];
                        MIR_HORIZONTAL: new_res.nametable_page = ppu_addr[11];
                        MIR_SINGLE_LO:  new_res.nametable_page = 1'b0;
                        MIR_SINGLE_HI:  new_res.nametable_page = 1'b1;
                        default:        new_res.nametable_page = 1'b0;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output buffer: the skid entry always holds the younger result.
    always_comb
    begin
        res_next        = res_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                res_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                res_next       = new_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_next       = new_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg              <= VAR_VRC4B;
            last_prg_bank_reg        <= 8'd31;
            ram_present_reg          <= 1'b1;
            prg_switch_bank_reg      <= '0;
            prg_middle_bank_reg      <= '0;
            prg_swap_mode_reg        <= 1'b0;
            chr_bank_reg             <= '{default: '0};
            mirror_mode_reg          <= MIR_VERTICAL;
            irq_latch_reg            <= '0;
            irq_count_reg            <= '0;
            irq_enabled_reg          <= 1'b0;
            irq_enable_after_ack_reg <= 1'b0;
            irq_cycle_mode_reg       <= 1'b0;
            prescaler_reg            <= PRESCALE_RELOAD;
            irq_pending_reg          <= 1'b0;
            out_valid_reg            <= 1'b0;
            skid_valid_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_VARIANT:       variant_reg       <= cfg_data[3:0];
                    CFG_LAST_PRG_BANK: last_prg_bank_reg <= cfg_data;
                    CFG_RAM_PRESENT:   ram_present_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            prg_switch_bank_reg      <= prg_switch_bank_next;
            prg_middle_bank_reg      <= prg_middle_bank_next;
            prg_swap_mode_reg        <= prg_swap_mode_next;
            chr_bank_reg             <= chr_bank_next;
            mirror_mode_reg          <= mirror_mode_next;
            irq_latch_reg            <= irq_latch_next;
            irq_count_reg            <= irq_count_next;
            irq_enabled_reg          <= irq_enabled_next;
            irq_enable_after_ack_reg <= irq_enable_after_ack_next;
            irq_cycle_mode_reg       <= irq_cycle_mode_next;
            prescaler_reg            <= prescaler_next;
            irq_pending_reg          <= irq_pending_next;
            out_valid_reg            <= out_valid_next;
            skid_valid_reg           <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign irq_line       = res_reg.irq_line;
    assign target         = res_reg.target;
    assign bank           = res_reg.bank;
    assign nametable_page = res_reg.nametable_page;

    // The skid entry is only ever filled behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry holds an item without a result in front of it.");

    // The prescaler stays within the span its reload and step allow.
    assert property (@(posedge clk) disable iff (!rst_n)
        (prescaler_reg <= PRESCALE_RELOAD) && (prescaler_reg >= PRESCALE_MIN))
        else $error("IRQ prescaler left its legal range.");

    // On VRC2 boards a tick leaves the IRQ counter and prescaler alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_TICK && is_vrc2) |=>
            ($stable(irq_count_reg) && $stable(prescaler_reg)))
        else $error("Tick changed IRQ state on a VRC2 variant.");

    // A newly loaded result reports the IRQ level held by the mapper.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !skid_valid_reg && (!out_valid_reg || out_ready)) |=>
            (res_reg.irq_line == irq_pending_reg))
        else $error("Result IRQ level differs from the pending flag.");

endmodule

[hdl/vrc4_pin_decode.sv]
// ----------------------------------------------------------------------------
// VRC2/VRC4 register pin decode
// Maps a CPU write address onto a register group and sub-register number
// according to the board variant's wiring of the low address lines.
// ----------------------------------------------------------------------------
module vrc4_pin_decode
    import vrc4_pkg::*;
(
    input  logic [3:0]  variant,
    input  logic [15:0] address,
    output wr_reg_t     reg_sel
);

    function automatic logic [1:0] exact_sub(
        input logic [7:0] a,
        input logic [7:0] m3,
        input logic [7:0] m2,
        input logic [7:0] m1
    );
        logic [1:0] s;
        begin
            if ((a & m3) == m3)
            begin
                s = 2'd3;
            end
            else if ((a & m2) == m2)
            begin
                s = 2'd2;
            end
            else if ((a & m1) == m1)
            begin
                s = 2'd1;
            end
            else
            begin
                s = 2'd0;
            end
            return s;
        end
    endfunction

    function automatic logic [1:0] legacy_sub(
        input logic [7:0] a,
        input logic [7:0] m3a,
        input logic [7:0] m3b,
        input logic [7:0] m2,
        input logic [7:0] m1
    );
        logic [1:0] s;
        begin
            if (((a & m3a) == m3a) || ((a & m3b) == m3b))
            begin
                s = 2'd3;
            end
            else if ((a & m2) != 8'h00)
            begin
                s = 2'd2;
            end
            else if ((a & m1) != 8'h00)
            begin
                s = 2'd1;
            end
            else
            begin
                s = 2'd0;
            end
            return s;
        end
    endfunction

    logic [7:0] lo;

    assign lo = address[7:0];

    always_comb
    begin
        reg_sel.grp = address[15:12];
        unique case (variant)
            VAR_VRC2A, VAR_VRC2C, VAR_VRC4B:
                reg_sel.sub = exact_sub(lo, 8'h03, 8'h01, 8'h02);
            VAR_VRC2B, VAR_VRC4F:
                reg_sel.sub = exact_sub(lo, 8'h03, 8'h02, 8'h01);
            VAR_VRC4A:
                reg_sel.sub = exact_sub(lo, 8'h06, 8'h04, 8'h02);
            VAR_VRC4C:
                reg_sel.sub = exact_sub(lo, 8'hC0, 8'h80, 8'h40);
            VAR_VRC4D:
                reg_sel.sub = exact_sub(lo, 8'h0C, 8'h04, 8'h08);
            VAR_VRC4E:
                reg_sel.sub = exact_sub(lo, 8'h0C, 8'h08, 8'h04);
            VAR_MAP23:
                reg_sel.sub = legacy_sub(lo, 8'h0C, 8'h03, 8'h0A, 8'h05);
            VAR_MAP25:
                reg_sel.sub = legacy_sub(lo, 8'h0C, 8'h03, 8'h05, 8'h0A);
            default:
                reg_sel.sub = legacy_sub(lo, 8'h06, 8'hC0, 8'h84, 8'h42);
        endcase
    end

endmodule

[tb/sv/vrc4_mapper_checker.sv]
// ----------------------------------------------------------------------------
// VRC2/VRC4 mapper result checker
// Watches the command, result and register channels of the mapper, keeps its
// own copy of the bank, mirroring and IRQ state, predicts the result of every
// accepted item and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module vrc4_mapper_checker
    import vrc4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  command,
    input  logic [15:0] address,
    input  logic [7:0]  data,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        irq_line,
    input  logic [2:0]  target,
    input  logic [8:0]  bank,
    input  logic        nametable_page,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    output int          fail_count,
    output int          results_due
);

    logic [3:0] variant_cfg;
    logic [7:0] top_bank_cfg;
    logic       ram_cfg;

    logic [4:0] prg_lo_bank;
    logic [4:0] prg_mid_bank;
    logic       prg_swapped;
    logic [8:0] chr_page [8];
    logic [1:0] mirroring;
    logic [7:0] irq_reload;
    logic [7:0] irq_counter;
    logic       irq_armed;
    logic       irq_rearm;
    logic       irq_cpu_mode;
    int         scanline_div;
    logic       irq_flag;

    result_t    mapper_results_due [$];

    function automatic void reset_mapper_state();
        variant_cfg   = VAR_VRC4B;
        top_bank_cfg  = 8'd31;
        ram_cfg       = 1'b1;
        prg_lo_bank   = '0;
        prg_mid_bank  = '0;
        prg_swapped   = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            chr_page[i] = '0;
        end
        mirroring     = MIR_VERTICAL;
        irq_reload    = '0;
        irq_counter   = '0;
        irq_armed     = 1'b0;
        irq_rearm     = 1'b0;
        irq_cpu_mode  = 1'b0;
        scanline_div  = int'(PRESCALE_RELOAD);
        irq_flag      = 1'b0;
    endfunction

    function automatic bit is_vrc2();
        return variant_cfg <= VAR_VRC2C;
    endfunction

    function automatic logic [1:0] exact_pins(input logic [7:0] lo, m3, m2, m1);
        if ((lo & m3) == m3)
            return 2'd3;
        if ((lo & m2) == m2)
            return 2'd2;
        if ((lo & m1) == m1)
            return 2'd1;
        return 2'd0;
    endfunction

    function automatic logic [1:0] legacy_pins(input logic [7:0] lo, m3a, m3b, m2, m1);
        if ((lo & m3a) == m3a || (lo & m3b) == m3b)
            return 2'd3;
        if ((lo & m2) != 8'h00)
            return 2'd2;
        if ((lo & m1) != 8'h00)
            return 2'd1;
        return 2'd0;
    endfunction

    function automatic logic [1:0] decode_pin_sub(input logic [7:0] lo);
        case (variant_cfg)
            VAR_VRC2A, VAR_VRC2C, VAR_VRC4B: return exact_pins(lo, 8'h03, 8'h01, 8'h02);
            VAR_VRC2B, VAR_VRC4F:            return exact_pins(lo, 8'h03, 8'h02, 8'h01);
            VAR_VRC4A:                       return exact_pins(lo, 8'h06, 8'h04, 8'h02);
            VAR_VRC4C:                       return exact_pins(lo, 8'hC0, 8'h80, 8'h40);
            VAR_VRC4D:                       return exact_pins(lo, 8'h0C, 8'h04, 8'h08);
            VAR_VRC4E:                       return exact_pins(lo, 8'h0C, 8'h08, 8'h04);
            VAR_MAP23:               return legacy_pins(lo, 8'h0C, 8'h03, 8'h0A, 8'h05);
            VAR_MAP25:               return legacy_pins(lo, 8'h0C, 8'h03, 8'h05, 8'h0A);
            default:                 return legacy_pins(lo, 8'h06, 8'hC0, 8'h84, 8'h42);
        endcase
    endfunction

    function automatic void apply_bus_write(input logic [15:0] a, input logic [7:0] v);
        logic [3:0] grp;
        logic [1:0] sub;
        logic [3:0] chr_grp;
        logic [2:0] idx;
        if (a < 16'h8000)
            return;
        grp     = a[15:12];
        sub     = decode_pin_sub(a[7:0]);
        chr_grp = grp - GRP_CHR_FIRST;
        idx     = {chr_grp[1:0], sub[1]};
        case (grp)
            GRP_PRG_SWITCH: prg_lo_bank = v[4:0];
            GRP_MIRROR:
            begin
                if (sub < 2'd2 || is_vrc2())
                    mirroring = is_vrc2() ? {1'b0, v[0]} : v[1:0];
                else
                    prg_swapped = v[1];
            end
            GRP_PRG_MIDDLE: prg_mid_bank = v[4:0];
            GRP_CHR_FIRST, GRP_CHR_1, GRP_CHR_2, GRP_CHR_LAST:
            begin
                if (!sub[0])
                    chr_page[idx][3:0] = v[3:0];
                else
                    chr_page[idx][8:4] = v[4:0];
            end
            GRP_IRQ:
            begin
                case (sub)
                    IRQ_LATCH_LO: irq_reload[3:0] = v[3:0];
                    IRQ_LATCH_HI: irq_reload[7:4] = v[3:0];
                    IRQ_CONTROL:
                    begin
                        irq_rearm    = v[0];
                        irq_armed    = v[1];
                        irq_cpu_mode = v[2];
                        if (irq_armed)
                        begin
                            irq_counter  = irq_reload;
                            scanline_div = int'(PRESCALE_RELOAD);
                        end
                        irq_flag = 1'b0;
                    end
                    default:
                    begin
                        irq_flag  = 1'b0;
                        irq_armed = irq_rearm;
                    end
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic void advance_irq_clock();
        logic fire;
        if (is_vrc2())
            return;
        fire = irq_cpu_mode;
        if (scanline_div <= 0)
        begin
            if (!irq_cpu_mode)
                fire = 1'b1;
            scanline_div += int'(PRESCALE_RELOAD);
        end
        scanline_div -= int'(PRESCALE_STEP);
        if (irq_armed && fire)
        begin
            if (irq_counter == IRQ_COUNT_TOP)
            begin
                irq_flag    = 1'b1;
                irq_counter = irq_reload;
            end
            else
            begin
                irq_counter = irq_counter + 8'd1;
            end
        end
    endfunction

    function automatic result_t predict_mapper_item(input logic [1:0] cmd,
                                                    input logic [15:0] a,
                                                    input logic [7:0] v);
        result_t    r;
        logic [7:0] second_last;
        logic [13:0] p;
        logic [8:0] chr;
        r           = '0;
        second_last = top_bank_cfg - 8'd1;
        p           = a[13:0];
        chr         = chr_page[p[12:10]];
        case (cmd_t'(cmd))
            CMD_WRITE: apply_bus_write(a, v);
            CMD_TICK:  advance_irq_clock();
            CMD_CPU_XLATE:
            begin
                if (a >= 16'h6000 && a < 16'h8000)
                begin
                    if (ram_cfg)
                        r.target = TGT_PRG_RAM;
                end
                else if (a >= 16'h8000)
                begin
                    r.target = TGT_PRG_ROM;
                    case (a[14:13])
                        2'd0: r.bank = prg_swapped ? {1'b0, second_last}
                                                   : {4'd0, prg_lo_bank};
                        2'd1: r.bank = {4'd0, prg_mid_bank};
                        2'd2: r.bank = prg_swapped ? {4'd0, prg_lo_bank}
                                                   : {1'b0, second_last};
                        default: r.bank = {1'b0, top_bank_cfg};
                    endcase
                end
            end
            default:
            begin
                if (p < 14'h2000)
                begin
                    r.target = TGT_CHR_ROM;
                    r.bank   = (variant_cfg == VAR_VRC2A) ? (chr >> 1) : chr;
                end
                else if (p < 14'h3F00)
                begin
                    r.target = TGT_NAMETABLE;
                    case (mirroring)
                        MIR_VERTICAL:   r.nametable_page = p[10];
                        MIR_HORIZONTAL: r.nametable_page = p[11];
                        MIR_SINGLE_LO:  r.nametable_page = 1'b0;
                        default:        r.nametable_page = 1'b1;
                    endcase
                end
            end
        endcase
        r.irq_line = irq_flag;
        return r;
    endfunction

    function automatic void report_failure(input string what, input result_t want,
                                           input result_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s: expected irq %0d target %0d bank %0d page %0d", $time, what,
                     want.irq_line, want.target, want.bank, want.nametable_page);
            $display("    got irq %0d target %0d bank %0d page %0d",
                     got.irq_line, got.target, got.bank, got.nametable_page);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            reset_mapper_state();
            mapper_results_due.delete();
            fail_count  = 0;
            results_due = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.irq_line       = irq_line;
                got.target         = target;
                got.bank           = bank;
                got.nametable_page = nametable_page;
                if (mapper_results_due.size() == 0)
                begin
                    report_failure("result item with nothing expected", '0, got);
                end
                else
                begin
                    want = mapper_results_due.pop_front();
                    if (got.irq_line !== want.irq_line || got.target !== want.target ||
                        got.bank !== want.bank ||
                        got.nametable_page !== want.nametable_page)
                        report_failure("result mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VARIANT:       variant_cfg  = cfg_data[3:0];
                    CFG_LAST_PRG_BANK: top_bank_cfg = cfg_data;
                    CFG_RAM_PRESENT:   ram_cfg      = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                mapper_results_due.push_back(predict_mapper_item(command, address, data));
            results_due = mapper_results_due.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// VRC2/VRC4 mapper testbench top
// Drives directed and random command items into the mapper under bursty
// traffic and a stalling receiver, steps through every variant and several
// PRG bank and RAM settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top
    import vrc4_pkg::*;
();

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_ready;
    logic        irq_line;
    logic [2:0]  target;
    logic [8:0]  bank;
    logic        nametable_page;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    int          fail_count;
    int          results_due;
    logic [3:0]  active_variant;
    int          items_sent;
    int          burst_left;

    vrc4_mapper_banking_irq dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .address        (address),
        .data           (data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .irq_line       (irq_line),
        .target         (target),
        .bank           (bank),
        .nametable_page (nametable_page),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    vrc4_mapper_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .address        (address),
        .data           (data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .irq_line       (irq_line),
        .target         (target),
        .bank           (bank),
        .nametable_page (nametable_page),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .results_due    (results_due)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Low address byte that selects register 0..3 of a group for the given variant.
    function automatic logic [7:0] pin_byte(input logic [3:0] v, input logic [1:0] sub);
        logic [7:0] lo1;
        logic [7:0] lo2;
        logic [7:0] lo3;
        case (v)
            VAR_VRC2A, VAR_VRC2C, VAR_VRC4B:
            begin
                lo1 = 8'h02; lo2 = 8'h01; lo3 = 8'h03;
            end
            VAR_VRC2B, VAR_VRC4F:
            begin
                lo1 = 8'h01; lo2 = 8'h02; lo3 = 8'h03;
            end
            VAR_VRC4C:
            begin
                lo1 = 8'h40; lo2 = 8'h80; lo3 = 8'hC0;
            end
            VAR_VRC4D:
            begin
                lo1 = 8'h08; lo2 = 8'h04; lo3 = 8'h0C;
            end
            VAR_VRC4E:
            begin
                lo1 = 8'h04; lo2 = 8'h08; lo3 = 8'h0C;
            end
            VAR_MAP23:
            begin
                lo1 = 8'h01; lo2 = 8'h08; lo3 = 8'h03;
            end
            VAR_MAP25:
            begin
                lo1 = 8'h02; lo2 = 8'h01; lo3 = 8'h03;
            end
            default:
            begin
                lo1 = 8'h02; lo2 = 8'h04; lo3 = 8'h06;
            end
        endcase
        case (sub)
            2'd1:    return lo1;
            2'd2:    return lo2;
            2'd3:    return lo3;
            default: return 8'h00;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= c;
        address  <= a;
        data     <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
    endtask

    task automatic send_write(input logic [3:0] grp, input logic [1:0] sub,
                              input logic [7:0] d);
        logic [15:0] a;
        a        = 16'($urandom);
        a[15:12] = grp;
        a[7:0]   = pin_byte(active_variant, sub);
        send_item(CMD_WRITE, a, d);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
    endtask

    task automatic irq_run(input bit scanline);
        logic [7:0] reload;
        logic [7:0] rnd;
        logic [7:0] ctl;
        int         ticks;
        reload = scanline ? (8'hFE | 8'($urandom_range(0, 1)))
                          : 8'($urandom_range(8'hD0, 8'hFF));
        rnd    = 8'($urandom);
        send_write(GRP_IRQ, IRQ_LATCH_LO, {rnd[7:4], reload[3:0]});
        send_write(GRP_IRQ, IRQ_LATCH_HI, {rnd[3:0], reload[7:4]});
        ctl    = 8'($urandom);
        ctl[2] = !scanline;
        ctl[1] = ($urandom_range(0, 9) != 0);
        send_write(GRP_IRQ, IRQ_CONTROL, ctl);
        ticks = scanline ? $urandom_range(115, 240) : $urandom_range(5, 60);
        repeat (ticks)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_PPU_XLATE, 16'($urandom), 8'($urandom));
            else
                send_item(CMD_TICK, 16'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 1) == 1)
            send_write(GRP_IRQ, IRQ_ACK, 8'($urandom));
    endtask

    task automatic random_action();
        int          pick;
        logic [15:0] a;
        logic [7:0]  d;
        pick = $urandom_range(0, 99);
        a    = 16'($urandom);
        d    = 8'($urandom);
        if (pick < 40)
        begin
            a[15:12] = 4'($urandom_range(8, 15));
            if ($urandom_range(0, 9) < 7)
                a[7:0] = pin_byte(active_variant, 2'($urandom_range(0, 3)));
            send_item(CMD_WRITE, a, d);
        end
        else if (pick < 55)
        begin
            repeat ($urandom_range(1, 8))
                send_item(CMD_TICK, a, d);
        end
        else if (pick < 70)
        begin
            if ($urandom_range(0, 9) < 7)
                a = 16'($urandom_range(16'h6000, 16'hFFFF));
            send_item(CMD_CPU_XLATE, a, d);
        end
        else if (pick < 85)
        begin
            send_item(CMD_PPU_XLATE, a, d);
        end
        else if (pick < 95)
        begin
            send_item(2'($urandom_range(0, 3)), a, d);
        end
        else
        begin
            irq_run($urandom_range(0, 19) == 0 && active_variant > VAR_VRC2C);
        end
    endtask

    initial
    begin
        int          mode;
        int          span;
        out_ready = 1'b0;
        @(posedge rst_n);
        repeat (150)
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 3) != 0);
        end
        repeat (90)
        begin
            @(negedge clk);
            out_ready <= 1'b0;
        end
        forever
        begin
            mode = $urandom_range(0, 7);
            span = (mode == 0) ? $urandom_range(20, 60) : $urandom_range(1, 50);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b0;
                    1, 2, 3: out_ready <= 1'b1;
                    default: out_ready <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [7:0] top_prg_bank;
        logic [7:0] rnd;
        logic       ram_on;
        int         quota;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_WRITE;
        address        = '0;
        data           = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_VARIANT;
        cfg_data       = '0;
        active_variant = VAR_VRC4B;
        items_sent     = 0;
        burst_left     = 8;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(CMD_WRITE, 16'h8000, 8'hFF);
        send_item(CMD_WRITE, 16'hA000, 8'hE0);
        send_item(CMD_CPU_XLATE, 16'h8000, 8'h00);
        send_item(CMD_CPU_XLATE, 16'hFFFF, 8'hFF);
        send_item(CMD_WRITE, 16'h9001, 8'h02);
        send_item(CMD_CPU_XLATE, 16'h8000, 8'h00);
        send_item(CMD_CPU_XLATE, 16'hC000, 8'h00);
        send_item(CMD_CPU_XLATE, 16'h5FFF, 8'h00);
        send_item(CMD_CPU_XLATE, 16'h6000, 8'h00);
        send_item(CMD_WRITE, 16'hB000, 8'hFF);
        send_item(CMD_WRITE, 16'hB002, 8'hFF);
        send_item(CMD_PPU_XLATE, 16'h0000, 8'h00);
        send_item(CMD_WRITE, 16'h9000, 8'h03);
        send_item(CMD_PPU_XLATE, 16'h2000, 8'h00);
        send_item(CMD_PPU_XLATE, 16'hFFFF, 8'h00);
        send_item(CMD_PPU_XLATE, 16'h3F00, 8'h00);
        send_item(CMD_PPU_XLATE, 16'h3EFF, 8'h00);
        send_item(CMD_WRITE, 16'h7000, 8'h55);
        send_item(CMD_WRITE, 16'h0000, 8'hFF);
        send_item(CMD_WRITE, 16'hF000, 8'h0F);
        send_item(CMD_WRITE, 16'hF002, 8'h0F);
        send_item(CMD_WRITE, 16'hF001, 8'h07);
        send_item(CMD_TICK, 16'h0000, 8'h00);
        send_item(CMD_WRITE, 16'hF003, 8'h00);
        send_item(CMD_TICK, 16'hFFFF, 8'hFF);

        for (int p = 0; p < 16; p++)
        begin
            wait_drained();
            repeat (2)
                @(negedge clk);
            case (p % 5)
                0:       top_prg_bank = 8'd255;
                1:       top_prg_bank = 8'd0;
                2:       top_prg_bank = 8'd1;
                3:       top_prg_bank = 8'd31;
                default: top_prg_bank = 8'($urandom_range(2, 254));
            endcase
            rnd            = 8'($urandom);
            ram_on         = (p % 3 != 1);
            active_variant = 4'(p);
            cfg_write(CFG_VARIANT, {rnd[7:4], active_variant});
            cfg_write(CFG_LAST_PRG_BANK, top_prg_bank);
            cfg_write(CFG_RAM_PRESENT, {rnd[7:1], ram_on});
            if (p == 0)
                cfg_write(CFG_UNUSED, rnd);
            if (active_variant == VAR_VRC4A || active_variant == VAR_VRC4C)
                irq_run(1'b1);
            quota = items_sent + 70;
            while (items_sent < quota)
                random_action();
        end

        wait_drained();
        repeat (5)
            @(negedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[vrc4_mapper_banking_irq.f]
hdl/vrc4_pkg.sv
hdl/vrc4_pin_decode.sv
hdl/vrc4_mapper_banking_irq.sv
tb/sv/vrc4_mapper_checker.sv
tb/sv/tb_top.sv
